@@ hw/rtl/rws_pkg.sv @@
// Package for the roulette wheel selector: field widths, action codes,
// controller states and the reset value of the target register.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rws_pkg;

   localparam int SLOT_W   = 4;
   localparam int CHROM_W  = 10;
   localparam int RANDOM_W = 16;
   localparam int FIT_OUT_W = 4;

   localparam logic [CHROM_W-1:0] TARGET_RESET = 10'd28;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SELECT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_UPD,
      ST_DIVIDE,
      ST_WALK,
      ST_DELIVER
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/rws_fit_mem.sv @@
// Fitness store: synchronous memory with a registered read port and a
// valid bit per entry so that entries never written read as zero.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rws_fit_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ hw/rtl/rws_divider.sv @@
// Restoring remainder unit: one dividend bit per cycle.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rws_divider #(
   parameter int DIVIDEND_W = 16,
   parameter int DIVISOR_W  = 9
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic      [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so the trial value
         // is below twice the divisor and one subtraction restores it.
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = DIVISOR_W'(trial);
         end
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ hw/rtl/roulette_wheel_selector.sv @@
// Roulette wheel selector, top level: controller, fitness count and the
// running total. Depends on rws_pkg, rws_fit_mem and rws_divider.
//
// Use: one word is taken on the req_ channel when req_valid is high and
// req_stall is low. A load word stores the fitness of req_chromosome (the
// number of gene bits equal to the target pattern) in slot req_slot and
// returns it with the slot echoed. A select word draws a slot with
// probability proportional to its fitness, using req_random_word.
// Each word gives exactly one result word on the rsp_ channel.
// Timing: one word is in flight at a time. A load passes through an update
// state to delivery, and a select with a zero total goes straight to delivery.
// Any other select first runs the bit-serial remainder unit over every bit
// of req_random_word, then walks the fitness memory from slot 0, one entry
// read per cycle, so its result comes later the higher the chosen slot.
// The result sits in an output register, so the next word is accepted while
// the previous result is still held under rsp_stall; a held result keeps
// the walk of the next word waiting only at its very end.
// Reset (synchronous) empties every slot, zeroes the total and sets the
// target pattern to its default. csr_wr_en writes the target pattern and is
// to be used only while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module roulette_wheel_selector
   import rws_pkg::*;
#(
   parameter int POOL_SIZE  = 16,
   parameter int GENE_COUNT = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_action,
   input  wire logic [SLOT_W-1:0]    req_slot,
   input  wire logic [CHROM_W-1:0]   req_chromosome,
   input  wire logic [RANDOM_W-1:0]  req_random_word,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [FIT_OUT_W-1:0] rsp_fitness,
   output logic      [SLOT_W-1:0]    rsp_chosen_slot,
   output logic                      rsp_zero_total,
   input  wire logic                 csr_wr_en,
   input  wire logic [CHROM_W-1:0]   csr_wr_data
);

   localparam int IDX_W     = $clog2(POOL_SIZE);
   localparam int CNT_W     = $clog2(POOL_SIZE + 1);
   localparam int FIT_W     = $clog2(GENE_COUNT + 1);
   localparam int TOTAL_MAX = POOL_SIZE * GENE_COUNT;
   localparam int TOTAL_W   = $clog2(TOTAL_MAX + 1);
   localparam int DIV_W     = TOTAL_W + 1;
   localparam logic [CHROM_W-1:0] GENE_MASK = (GENE_COUNT >= CHROM_W) ?
      {CHROM_W{1'b1}} : CHROM_W'((1 << GENE_COUNT) - 1);

   state_type state_ff, state_in;

   logic [CHROM_W-1:0]   target_ff;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [SLOT_W-1:0]    slot_ff;
   logic                 in_pool_ff;
   logic [FIT_W-1:0]     fit_ff;
   logic [TOTAL_W-1:0]   thresh_ff;
   logic [TOTAL_W-1:0]   prefix_ff;
   logic [CNT_W-1:0]     issue_ff;
   logic                 chk_vld_ff;
   logic [IDX_W-1:0]     chk_idx_ff;
   logic [FIT_W-1:0]     res_fit_ff;
   logic [SLOT_W-1:0]    res_slot_ff;
   logic                 res_zero_ff;
   logic                 rsp_valid_ff;
   logic [FIT_OUT_W-1:0] rsp_fit_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_zero_ff;

   logic                 accept;
   logic                 out_free;
   logic [CHROM_W-1:0]   diff;
   logic [FIT_W-1:0]     ones;
   logic [FIT_W-1:0]     fit_calc;
   logic                 mem_rd_en;
   logic [IDX_W-1:0]     mem_rd_addr;
   logic [FIT_W-1:0]     mem_rd_data;
   logic                 mem_wr_en;
   logic                 div_start;
   logic                 div_done;
   logic [DIV_W-1:0]     div_rem;
   logic [TOTAL_W-1:0]   prefix_sum;
   logic                 walk_hit;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Fitness is the gene count less the number of mismatching gene bits.
   always_comb begin
      diff = (req_chromosome ^ target_ff) & GENE_MASK;
      ones = '0;
      for (int i = 0; i < CHROM_W; i++) begin
         ones = ones + FIT_W'(diff[i]);
      end
      fit_calc = FIT_W'(GENE_COUNT) - ones;
   end

   rws_fit_mem #(
      .DEPTH (POOL_SIZE),
      .WIDTH (FIT_W)
   ) u_fit_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (IDX_W'(slot_ff)),
      .wr_data (fit_ff)
   );

   rws_divider #(
      .DIVIDEND_W (RANDOM_W),
      .DIVISOR_W  (DIV_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_random_word),
      .divisor   ({1'b0, total_ff} + DIV_W'(1)),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign prefix_sum = prefix_ff + TOTAL_W'(mem_rd_data);
   // The last slot ends the walk even when the prefix never passes the
   // threshold.
   assign walk_hit   = chk_vld_ff &&
                       ((prefix_sum > thresh_ff) || (chk_idx_ff == IDX_W'(POOL_SIZE - 1)));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACTION_LOAD) begin
                  state_in = ST_LOAD_UPD;
               end else if (total_ff == '0) begin
                  state_in = ST_DELIVER;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_LOAD_UPD: state_in = ST_DELIVER;
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_hit) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_stall   = 1'b1;
      mem_rd_en   = 1'b0;
      mem_rd_addr = issue_ff[IDX_W-1:0];
      mem_wr_en   = 1'b0;
      div_start   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            mem_rd_en   = req_valid && (req_action == ACTION_LOAD);
            mem_rd_addr = IDX_W'(req_slot);
            div_start   = req_valid && (req_action == ACTION_SELECT) && (total_ff != '0);
         end
         ST_LOAD_UPD: mem_wr_en = in_pool_ff;
         ST_DIVIDE:   ;
         ST_WALK:     mem_rd_en = (issue_ff < CNT_W'(POOL_SIZE));
         ST_DELIVER:  ;
         default:     ;
      endcase
   end

   always_comb begin
      total_in = total_ff;
      if ((state_ff == ST_LOAD_UPD) && in_pool_ff) begin
         total_in = total_ff - TOTAL_W'(mem_rd_data) + TOTAL_W'(fit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= TARGET_RESET;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
         if (state_ff == ST_DELIVER && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         chk_vld_ff <= (state_ff == ST_WALK) && mem_rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff    <= req_slot;
         in_pool_ff <= (int'(req_slot) < POOL_SIZE);
         fit_ff     <= fit_calc;
         if (req_action == ACTION_SELECT) begin
            res_fit_ff  <= '0;
            res_slot_ff <= '0;
            res_zero_ff <= (total_ff == '0);
         end
      end
      if (state_ff == ST_LOAD_UPD) begin
         res_fit_ff  <= fit_ff;
         res_slot_ff <= slot_ff;
         res_zero_ff <= 1'b0;
      end
      if (state_ff == ST_DIVIDE && div_done) begin
         // The first remainder never exceeds the total, so the second
         // reduction only folds the total itself back to zero.
         thresh_ff <= (div_rem == {1'b0, total_ff}) ? '0 : TOTAL_W'(div_rem);
         prefix_ff <= '0;
         issue_ff  <= '0;
      end
      if (state_ff == ST_WALK) begin
         if (mem_rd_en) begin
            issue_ff <= issue_ff + 1'b1;
         end
         chk_idx_ff <= mem_rd_addr;
         if (chk_vld_ff) begin
            prefix_ff <= prefix_sum;
         end
         if (walk_hit) begin
            res_fit_ff  <= mem_rd_data;
            res_slot_ff <= SLOT_W'(chk_idx_ff);
         end
      end
      if (state_ff == ST_DELIVER && out_free) begin
         rsp_fit_ff  <= FIT_OUT_W'(res_fit_ff);
         rsp_slot_ff <= res_slot_ff;
         rsp_zero_ff <= res_zero_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fitness     = rsp_fit_ff;
   assign rsp_chosen_slot = rsp_slot_ff;
   assign rsp_zero_total  = rsp_zero_ff;

   // A zero-total select must return slot 0 with zero fitness.
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_total) |-> (rsp_fitness == '0 && rsp_chosen_slot == '0))
      else $error("zero total word carries a non-zero slot or fitness");

   // The running total can never exceed every slot at full fitness.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOTAL_W'(TOTAL_MAX))
      else $error("running fitness total out of range");

   // The remainder unit only finishes while the controller waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("remainder unit finished outside the divide state");

   // A walk always ends within one pass over the pool.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && chk_vld_ff && chk_idx_ff == IDX_W'(POOL_SIZE - 1))
      |=> (state_ff == ST_DELIVER))
      else $error("selection walk ran past the last slot");

endmodule

`default_nettype wire
